@@ rtl/apfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_pkg
// Shared types, codes and field widths of the address pair flow classifier.
// ----------------------------------------------------------------------------
package apfc_pkg;

    localparam int ADDR_W   = 64;
    localparam int QUERY_W  = 7;
    localparam int FLOW_W   = 7;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 168;

    typedef enum logic {
        OP_CLASSIFY = 1'b0,
        OP_LOOKUP   = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTING  = 2'd0,
        ST_NEW_FLOW  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic lk_rd;
        logic fin_hit;
        logic fin_new;
        logic fin_full;
        logic fin_lk;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
    } dp_status_t;

endpackage

@@ rtl/apfc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_datapath
// Flow table memory, sequential search, counter update and result registers.
// ----------------------------------------------------------------------------
module apfc_datapath import apfc_pkg::*; #(
    parameter int MAX_FLOWS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic [ADDR_W-1:0]   in_src,
    input  logic [ADDR_W-1:0]   in_dst,
    input  logic [QUERY_W-1:0]  in_query,
    output dp_status_t          status,
    output logic [FLOW_W-1:0]   out_flow_id,
    output logic [COUNT_W-1:0]  out_packet_id,
    output logic [STATUS_W-1:0] out_status,
    output logic [ADDR_W-1:0]   out_found_src,
    output logic [ADDR_W-1:0]   out_found_dst
);

    localparam int AW = $clog2(MAX_FLOWS);
    localparam int CW = $clog2(MAX_FLOWS + 1);
    localparam int LW = (CW > QUERY_W) ? CW : QUERY_W;

    entry_t mem [MAX_FLOWS];

    logic [ADDR_W-1:0]   src_reg;
    logic [ADDR_W-1:0]   dst_reg;
    logic [QUERY_W-1:0]  query_reg;
    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       idx_reg;
    logic                cmp_valid_reg;
    logic [AW-1:0]       cmp_idx_reg;
    entry_t              rd_data_reg;
    logic [FLOW_W-1:0]   flow_id_reg;
    logic [COUNT_W-1:0]  packet_id_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   found_src_reg;
    logic [ADDR_W-1:0]   found_dst_reg;

    logic                hit;
    logic                issue;
    logic                step;
    logic [LW-1:0]       query_ext;
    logic [LW-1:0]       used_ext;
    logic [LW-1:0]       lk_addr_ext;
    logic                lk_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic [COUNT_W-1:0]  count_inc;
    logic [CW-1:0]       hit_fid;
    logic [CW-1:0]       new_fid;

    assign hit   = cmp_valid_reg && (rd_data_reg.src == src_reg)
                   && (rd_data_reg.dst == dst_reg);
    assign step  = cmd.scan && !hit;
    assign issue = step && (idx_reg < used_reg);

    assign query_ext   = LW'(query_reg);
    assign used_ext    = LW'(used_reg);
    assign lk_addr_ext = query_ext - LW'(1);
    assign lk_ok       = (query_ext != '0) && (query_ext <= used_ext);

    assign count_inc = rd_data_reg.count + COUNT_W'(1);
    assign hit_fid   = CW'(cmp_idx_reg) + CW'(1);
    assign new_fid   = used_reg + CW'(1);

    assign rd_en   = issue || cmd.lk_rd;
    assign rd_addr = cmd.lk_rd ? lk_addr_ext[AW-1:0] : idx_reg[AW-1:0];
    assign wr_en   = cmd.fin_hit || cmd.fin_new;
    assign wr_addr = cmd.fin_hit ? cmp_idx_reg : used_reg[AW-1:0];

    always_comb begin
        wr_data.src = src_reg;
        wr_data.dst = dst_reg;
        if (cmd.fin_hit) begin
            wr_data.count = count_inc;
        end else begin
            wr_data.count = '0;
        end
    end

    assign status.hit       = hit;
    assign status.scan_done = !cmp_valid_reg && (idx_reg >= used_reg);
    assign status.full      = (used_reg == CW'(MAX_FLOWS));

    // flow table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // item registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_reg   <= in_src;
            dst_reg   <= in_dst;
            query_reg <= in_query;
        end
        if (issue) begin
            cmp_idx_reg <= idx_reg[AW-1:0];
        end
    end

    // search control and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg       <= '0;
                cmp_valid_reg <= 1'b0;
            end else if (step) begin
                cmp_valid_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            if (cmd.fin_new) begin
                used_reg <= new_fid;
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        priority if (cmd.fin_hit) begin
            flow_id_reg   <= FLOW_W'(hit_fid);
            packet_id_reg <= count_inc;
            status_reg    <= ST_EXISTING;
            found_src_reg <= '0;
            found_dst_reg <= '0;
        end else if (cmd.fin_new) begin
            flow_id_reg   <= FLOW_W'(new_fid);
            packet_id_reg <= '0;
            status_reg    <= ST_NEW_FLOW;
            found_src_reg <= '0;
            found_dst_reg <= '0;
        end else if (cmd.fin_full || (cmd.fin_lk && !lk_ok)) begin
            flow_id_reg   <= '0;
            packet_id_reg <= '0;
            status_reg    <= cmd.fin_full ? ST_FULL : ST_NOT_FOUND;
            found_src_reg <= '0;
            found_dst_reg <= '0;
        end else if (cmd.fin_lk) begin
            flow_id_reg   <= FLOW_W'(query_reg);
            packet_id_reg <= rd_data_reg.count;
            status_reg    <= ST_EXISTING;
            found_src_reg <= rd_data_reg.src;
            found_dst_reg <= rd_data_reg.dst;
        end else begin
            flow_id_reg   <= flow_id_reg;
            packet_id_reg <= packet_id_reg;
            status_reg    <= status_reg;
            found_src_reg <= found_src_reg;
            found_dst_reg <= found_dst_reg;
        end
    end

    assign out_flow_id   = flow_id_reg;
    assign out_packet_id = packet_id_reg;
    assign out_status    = status_reg;
    assign out_found_src = found_src_reg;
    assign out_found_dst = found_dst_reg;

endmodule

@@ rtl/apfc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_ctrl
// Sequencer for search, lookup and result hand-off, with stream handshakes.
// ----------------------------------------------------------------------------
module apfc_ctrl import apfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       in_op,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_LK_RD   = 7'b0000100,
        S_LK_DONE = 7'b0001000,
        S_HIT     = 7'b0010000,
        S_NEW     = 7'b0100000,
        S_FULL    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;
    logic   finish;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (op_t'(in_op) == OP_LOOKUP) begin
                        state_next = S_LK_RD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                priority if (status.hit) begin
                    state_next = S_HIT;
                end else if (status.scan_done) begin
                    state_next = status.full ? S_FULL : S_NEW;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_LK_RD: begin
                cmd.lk_rd  = 1'b1;
                state_next = S_LK_DONE;
            end
            S_LK_DONE: begin
                if (out_free) begin
                    cmd.fin_lk = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HIT: begin
                if (out_free) begin
                    cmd.fin_hit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_NEW: begin
                if (out_free) begin
                    cmd.fin_new = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FULL: begin
                if (out_free) begin
                    cmd.fin_full = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign finish = cmd.fin_lk || cmd.fin_hit || cmd.fin_new || cmd.fin_full;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/address_pair_flow_classifier_core.sv @@
`timescale 1ns / 1ps
// classify: result valid once the scan of the flow table memory, one entry per cycle,
// stops at a hit or has passed every used slot (used = flows in the table) for a
// new pair or a full table
// lookup: one table read; one item in flight, the next is taken in the cycle in
// which the result becomes valid, while it waits in the output register
// reset (aresetn low, synchronous) empties the table and clears the handshakes
// ----------------------------------------------------------------------------
// address_pair_flow_classifier_core
// Exact-match flow table on source/destination pairs with per-flow counters.
// ----------------------------------------------------------------------------
module address_pair_flow_classifier_core import apfc_pkg::*; #(
    parameter int MAX_FLOWS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // src_addr, dst_addr, query_flow, pad
    input  logic                 s_tuser,  // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // flow_id, packet_id, found_src,
                                           // found_dst, pad
    output logic [STATUS_W-1:0]  m_tuser   // status
);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [FLOW_W-1:0]   flow_id;
    logic [COUNT_W-1:0]  packet_id;
    logic [STATUS_W-1:0] res_status;
    logic [ADDR_W-1:0]   found_src;
    logic [ADDR_W-1:0]   found_dst;

    apfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    apfc_datapath #(
        .MAX_FLOWS (MAX_FLOWS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_src        (s_tdata[ADDR_W-1:0]),
        .in_dst        (s_tdata[2*ADDR_W-1:ADDR_W]),
        .in_query      (s_tdata[2*ADDR_W+QUERY_W-1:2*ADDR_W]),
        .status        (status),
        .out_flow_id   (flow_id),
        .out_packet_id (packet_id),
        .out_status    (res_status),
        .out_found_src (found_src),
        .out_found_dst (found_dst)
    );

    assign m_tdata = {1'b0, found_dst, found_src, packet_id, flow_id};
    assign m_tuser = res_status;

endmodule

@@ tb/tb_address_pair_flow_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_pair_flow_classifier_core
// Self-checking bench for the address pair flow classifier. A scoreboard keeps
// its own flow table, predicts every reply from the accepted classify and
// lookup transfers, and compares each reply field by field. Directed frames
// cover the table edges, then random traffic fills the table past full.
// ----------------------------------------------------------------------------
package flow_table_tb_pkg;
    import apfc_pkg::*;

    localparam int TABLE_DEPTH = 64;

    typedef struct {
        logic [FLOW_W-1:0]  flow_id;
        logic [COUNT_W-1:0] packet_id;
        status_t            status;
        logic [ADDR_W-1:0]  found_src;
        logic [ADDR_W-1:0]  found_dst;
    } flow_reply_t;

    class flow_table_scoreboard;
        logic [ADDR_W-1:0]  tab_src[TABLE_DEPTH];
        logic [ADDR_W-1:0]  tab_dst[TABLE_DEPTH];
        logic [COUNT_W-1:0] tab_count[TABLE_DEPTH];
        int                 flows_used;
        flow_reply_t        pending_replies[$];
        int                 error_count;
        int                 reply_count;

        function new();
            flows_used  = 0;
            error_count = 0;
            reply_count = 0;
        endfunction

        function void note_frame(op_t op, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                 logic [QUERY_W-1:0] query);
            flow_reply_t r;
            int          slot;
            r.flow_id   = '0;
            r.packet_id = '0;
            r.status    = ST_EXISTING;
            r.found_src = '0;
            r.found_dst = '0;
            slot        = -1;
            if (op == OP_CLASSIFY) begin
                for (int k = 0; k < flows_used; k++) begin
                    if (slot < 0 && tab_src[k] == src && tab_dst[k] == dst) begin
                        slot = k;
                    end
                end
                if (slot >= 0) begin
                    tab_count[slot] = tab_count[slot] + 1'b1;
                    r.flow_id       = FLOW_W'(slot + 1);
                    r.packet_id     = tab_count[slot];
                end else if (flows_used < TABLE_DEPTH) begin
                    tab_src[flows_used]   = src;
                    tab_dst[flows_used]   = dst;
                    tab_count[flows_used] = '0;
                    flows_used++;
                    r.flow_id = FLOW_W'(flows_used);
                    r.status  = ST_NEW_FLOW;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (query >= 1 && query <= flows_used) begin
                r.flow_id   = query;
                r.packet_id = tab_count[query - 1];
                r.found_src = tab_src[query - 1];
                r.found_dst = tab_dst[query - 1];
            end else begin
                r.status = ST_NOT_FOUND;
            end
            pending_replies.push_back(r);
        endfunction

        task report_error(string msg);
            error_count++;
            if (error_count <= 40) begin
                $display("ERROR reply %0d: %s", reply_count, msg);
            end
        endtask

        task check_reply(flow_reply_t got);
            flow_reply_t want;
            reply_count++;
            if (pending_replies.size() == 0) begin
                report_error("reply with nothing outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (got.flow_id !== want.flow_id)
                    report_error($sformatf("flow_id %0d, predicted %0d",
                                           got.flow_id, want.flow_id));
                if (got.packet_id !== want.packet_id)
                    report_error($sformatf("packet_id %0d, predicted %0d",
                                           got.packet_id, want.packet_id));
                if (got.status !== want.status)
                    report_error($sformatf("status %0d, predicted %0d",
                                           got.status, want.status));
                if (got.found_src !== want.found_src)
                    report_error($sformatf("found_src %h, predicted %h",
                                           got.found_src, want.found_src));
                if (got.found_dst !== want.found_dst)
                    report_error($sformatf("found_dst %h, predicted %h",
                                           got.found_dst, want.found_dst));
            end
        endtask
    endclass
endpackage

module tb_address_pair_flow_classifier_core;
    import apfc_pkg::*;
    import flow_table_tb_pkg::*;

    localparam int RANDOM_FRAMES = 2000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 100;
    localparam logic [ADDR_W-1:0] ONES = '1;
    localparam logic [ADDR_W-1:0] ALT_A = 64'haaaa_aaaa_aaaa_aaaa;
    localparam logic [ADDR_W-1:0] ALT_5 = 64'h5555_5555_5555_5555;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    flow_table_scoreboard flow_sb;
    int                   tx_idle_pct   = 7;
    int                   rx_idle_pct   = 45;
    bit                   hold_request  = 1'b0;
    bit                   hold_active   = 1'b0;
    int                   cycle_count   = 0;
    logic [ADDR_W-1:0]    pool_src[$];
    logic [ADDR_W-1:0]    pool_dst[$];

    address_pair_flow_classifier_core #(
        .MAX_FLOWS(TABLE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("address_pair_flow_classifier_core: mismatch");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up onto its input
    initial begin
        wait (hold_request);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        flow_reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.flow_id   = m_tdata[6:0];
            got.packet_id = m_tdata[38:7];
            got.status    = status_t'(m_tuser);
            got.found_src = m_tdata[102:39];
            got.found_dst = m_tdata[166:103];
            flow_sb.check_reply(got);
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_frame(input op_t op, input logic [ADDR_W-1:0] src,
                              input logic [ADDR_W-1:0] dst, input logic [QUERY_W-1:0] query);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, query, dst, src};
        do @(posedge aclk); while (!s_tready);
        flow_sb.note_frame(op, src, dst, query);
        @(negedge aclk);
    endtask

    task automatic send_random_frame();
        int                pick;
        int                idx;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        pick = $urandom_range(99);
        if (pick < 20) begin
            send_frame(OP_LOOKUP, rand_addr(), rand_addr(), QUERY_W'($urandom_range(64)));
        end else if (pick < 30 || pool_src.size() == 0) begin
            src = rand_addr();
            dst = rand_addr();
            // partial matches against a known pair
            if (pool_src.size() != 0 && pick % 3 == 1) begin
                src = pool_src[$urandom_range(pool_src.size() - 1)];
            end else if (pool_src.size() != 0 && pick % 3 == 2) begin
                dst = pool_dst[$urandom_range(pool_dst.size() - 1)];
            end
            pool_src.push_back(src);
            pool_dst.push_back(dst);
            send_frame(OP_CLASSIFY, src, dst, QUERY_W'($urandom_range(64)));
        end else begin
            idx = $urandom_range(pool_src.size() - 1);
            send_frame(OP_CLASSIFY, pool_src[idx], pool_dst[idx], QUERY_W'($urandom_range(64)));
        end
    endtask

    initial begin
        flow_sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table lookups, edge addresses, partial matches, repeats
        send_frame(OP_LOOKUP, '0, '0, 7'd0);
        send_frame(OP_LOOKUP, ONES, ONES, 7'd1);
        send_frame(OP_LOOKUP, '0, '0, 7'd64);
        send_frame(OP_CLASSIFY, '0, '0, 7'd0);
        send_frame(OP_CLASSIFY, ONES, ONES, 7'd64);
        send_frame(OP_CLASSIFY, '0, ONES, 7'd0);
        send_frame(OP_CLASSIFY, ONES, '0, 7'd0);
        send_frame(OP_CLASSIFY, '0, '0, 7'd0);
        send_frame(OP_CLASSIFY, '0, '0, 7'd63);
        send_frame(OP_LOOKUP, '0, '0, 7'd1);
        send_frame(OP_LOOKUP, '0, '0, 7'd4);
        send_frame(OP_LOOKUP, '0, '0, 7'd5);
        send_frame(OP_LOOKUP, ONES, ONES, 7'd0);
        send_frame(OP_CLASSIFY, ALT_A, ALT_5, 7'd0);
        send_frame(OP_CLASSIFY, ALT_5, ALT_A, 7'd0);
        send_frame(OP_LOOKUP, ALT_A, ALT_5, 7'd6);
        send_frame(OP_CLASSIFY, ONES, ONES, 7'd0);
        pool_src = '{64'd0, ONES, 64'd0, ONES, ALT_A, ALT_5};
        pool_dst = '{64'd0, ONES, ONES, 64'd0, ALT_5, ALT_A};

        for (int i = 0; i < RANDOM_FRAMES; i++) begin
            if (i == 700) begin
                tx_idle_pct = 45;
                rx_idle_pct = 7;
            end else if (i == 1400) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 300) begin
                hold_request = 1'b1;
            end
            if (i == 1000) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (flow_sb.pending_replies.size() != 0) @(negedge aclk);
            end
            send_random_frame();
        end
        s_tvalid <= 1'b0;

        while (flow_sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (flow_sb.error_count == 0 && flow_sb.pending_replies.size() == 0) begin
            $display("address_pair_flow_classifier_core: match");
        end else begin
            $display("address_pair_flow_classifier_core: mismatch");
        end
        $finish;
    end

endmodule
